[hdl/c8x_pkg.sv]
// c8x_pkg: shared types and constants for the CHIP-8 executor core.
// Depends on nothing; imported by every module under hdl.
package c8x_pkg;

    localparam logic [11:0] PROG_START = 12'h200;

    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_OP    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // ALU operations of the shared unit
    typedef enum logic [3:0] {
        ALU_PASS_B = 4'd0,
        ALU_OR     = 4'd1,
        ALU_AND    = 4'd2,
        ALU_XOR    = 4'd3,
        ALU_ADD    = 4'd4,
        ALU_SUB    = 4'd5,
        ALU_RSUB   = 4'd6,
        ALU_SHR    = 4'd7,
        ALU_SHL    = 4'd8
    } alu_op_t;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
    } alu_out_t;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] f;
        begin
            f = 8'h00;
            case (a)
                7'd0: f = 8'hF0;  7'd1: f = 8'h90;  7'd2: f = 8'h90;  7'd3: f = 8'h90;
                7'd4: f = 8'hF0;  7'd5: f = 8'h20;  7'd6: f = 8'h60;  7'd7: f = 8'h20;
                7'd8: f = 8'h20;  7'd9: f = 8'h70;  7'd10: f = 8'hF0; 7'd11: f = 8'h10;
                7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
                7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
                7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
                7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
                7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
                7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
                7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
                7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
                7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
                7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
                7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
                7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
                7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
                7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
                7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
                7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
                7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
                default: f = 8'h00;
            endcase
            font_byte = f;
        end
    endfunction

endpackage

[hdl/c8x_alu.sv]
// c8x_alu: shared 8-bit arithmetic, logic and shift unit with flag output.
// Depends on c8x_pkg.
module c8x_alu
    import c8x_pkg::*;
(
    input  alu_op_t    op,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output alu_out_t   y
);

    logic [8:0] sum;

    always_comb
    begin
        sum = {1'b0, a} + {1'b0, b};
        y.res  = b;
        y.flag = 1'b0;
        case (op)
            ALU_PASS_B: y.res = b;
            ALU_OR:     y.res = a | b;
            ALU_AND:    y.res = a & b;
            ALU_XOR:    y.res = a ^ b;
            ALU_ADD:
            begin
                y.res  = sum[7:0];
                y.flag = sum[8];
            end
            ALU_SUB:
            begin
                y.res  = a - b;
                y.flag = (a >= b);
            end
            ALU_RSUB:
            begin
                y.res  = b - a;
                y.flag = (b >= a);
            end
            ALU_SHR:
            begin
                y.res  = {1'b0, b[7:1]};
                y.flag = b[0];
            end
            ALU_SHL:
            begin
                y.res  = {b[6:0], 1'b0};
                y.flag = b[7];
            end
            default:
            begin
                y.res  = b;
                y.flag = 1'b0;
            end
        endcase
    end

endmodule

[hdl/chip8_instruction_executor_core.sv]
// chip8_instruction_executor_core: CHIP-8 interpreter with a sequencer around a shared ALU.
// Depends on c8x_pkg and c8x_alu.
//
// An item is taken when start is high and busy is low; done is high for one cycle
// with the result on the result ports and cannot be held off. Timer, load and read
// items pass through S_ROW and S_OUT. An execute item runs the fetch (S_F0, S_F1,
// S_F2) and S_EXEC, then its work: DXYN S_DRD and S_DRW per sprite row, 00E0 one
// frame-buffer row per cycle, FX55/FX65 one register at a time in S_MST/S_MLD, FX33
// S_BCD then S_BCDW (the BCD digits come from repeated subtraction on the ALU).
// Memory is a byte array with one write port and one registered read port, which sets
// the per-byte pace. Bytes above 79 that were never loaded are undefined.
module chip8_instruction_executor_core
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] keys_down,
    input  logic [7:0]  random_byte,
    input  logic [11:0] load_address,
    input  logic [7:0]  load_data,
    input  logic [4:0]  row_select,
    output logic        done,
    output logic [1:0]  status,
    output logic [11:0] pc_now,
    output logic [15:0] index_now,
    output logic [63:0] row_pixels,
    output logic        sound_on,
    output logic        display_changed
);

    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_F0    = 14'b00000000000010,
        S_F1    = 14'b00000000000100,
        S_F2    = 14'b00000000001000,
        S_EXEC  = 14'b00000000010000,
        S_CLR   = 14'b00000000100000,
        S_DRD   = 14'b00000001000000,
        S_DRW   = 14'b00000010000000,
        S_BCD   = 14'b00000100000000,
        S_BCDW  = 14'b00001000000000,
        S_MST   = 14'b00010000000000,
        S_MLD   = 14'b00100000000000,
        S_ROW   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // memory (font region is a constant overlay until written)
    logic [7:0]  mem [0:4095];
    logic [79:0] fw_reg;
    logic [7:0]  mem_q;
    logic [7:0]  mrd_reg;
    logic [11:0] raddr_reg;
    logic        rd_font_reg;
    logic        mem_we;
    logic [11:0] mem_wa;
    logic [7:0]  mem_wd;
    logic [11:0] mem_ra;

    logic [7:0]  v_reg [0:15];
    logic [63:0] fb_reg [0:31];
    logic [11:0] stk [0:STACK_DEPTH-1];
    logic [11:0] pc_reg;
    logic [15:0] i_reg;
    logic [SCW-1:0] sc_reg;
    logic [7:0]  dt_reg, st_reg;

    logic [1:0]  op_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [11:0] la_reg;
    logic [7:0]  ld_reg;
    logic [4:0]  rs_reg;
    logic [7:0]  b0_reg, b1_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  stat_reg;
    logic        chg_reg, hit_reg;
    logic [7:0]  acc_reg;
    logic [1:0]  dig_reg;
    logic [7:0]  d100_reg, d10_reg;

    logic [3:0]  xr, yr, nl;
    logic [7:0]  vx, vy;
    assign xr = b0_reg[3:0];
    assign yr = b1_reg[7:4];
    assign nl = b1_reg[3:0];
    assign vx = v_reg[xr];
    assign vy = v_reg[yr];

    alu_op_t  alu_op;
    logic [7:0] alu_a, alu_b;
    alu_out_t alu_y;

    c8x_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

    logic [7:0] rd_byte;
    assign rd_byte = (rd_font_reg && !fw_reg[raddr_reg[6:0]]) ?
                     font_byte(raddr_reg[6:0]) : mem_q;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_q <= mem[mem_ra];
    end

    // sprite helpers
    logic [5:0]  sx;
    logic [4:0]  srow;
    logic [63:0] smask;
    logic [3:0]  key_lo;
    logic        key_any;
    logic [11:0] pc_inc;

    assign sx     = vx[5:0];
    assign srow   = vy[4:0] + cnt_reg;
    assign pc_inc = pc_reg + 12'd2;

    always_comb
    begin
        smask = 64'd0;
        for (int c = 0; c < 8; c++)
        begin
            if (mrd_reg[7-c])
                smask[6'd63 - (sx + 6'(c))] = 1'b1;
        end
        key_lo  = 4'd0;
        key_any = 1'b0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                key_lo  = 4'(k);
                key_any = 1'b1;
            end
        end
    end

    logic        fw_set;
    logic [11:0] fw_addr;

    always_comb
    begin
        state_next = state_reg;
        mem_we  = 1'b0;
        mem_wa  = i_reg[11:0];
        mem_wd  = 8'd0;
        mem_ra  = pc_reg;
        alu_op  = ALU_PASS_B;
        alu_a   = vx;
        alu_b   = vy;
        case (state_reg)
            S_F0:   mem_ra = pc_reg;
            S_F1:   mem_ra = pc_reg + 12'd1;
            S_DRD:  mem_ra = i_reg[11:0] + 12'(cnt_reg);
            S_MLD:  mem_ra = i_reg[11:0] + 12'(cnt_reg);
            S_EXEC:
            begin
                if (b0_reg[7:4] == 4'h8)
                begin
                    case (nl)
                        4'h0: alu_op = ALU_PASS_B;
                        4'h1: alu_op = ALU_OR;
                        4'h2: alu_op = ALU_AND;
                        4'h3: alu_op = ALU_XOR;
                        4'h4: alu_op = ALU_ADD;
                        4'h5: alu_op = ALU_SUB;
                        4'h7: alu_op = ALU_RSUB;
                        4'h6: alu_op = ALU_SHR;
                        4'hE: alu_op = ALU_SHL;
                        default: alu_op = ALU_PASS_B;
                    endcase
                end
                else if (b0_reg[7:4] == 4'h7)
                begin
                    alu_op = ALU_ADD;
                    alu_b  = b1_reg;
                end
                else if (b0_reg[7:4] == 4'hC)
                begin
                    alu_op = ALU_AND;
                    alu_a  = rnd_reg;
                    alu_b  = b1_reg;
                end
                else if (b0_reg[7:4] == 4'hF && b1_reg == 8'h1E)
                begin
                    alu_op = ALU_ADD;
                    alu_a  = i_reg[7:0];
                    alu_b  = vx;
                end
            end
            S_BCD:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = (dig_reg == 2'd0) ? 8'd100 : 8'd10;
            end
            S_BCDW:
            begin
                mem_we = 1'b1;
                mem_wa = i_reg[11:0] + 12'(cnt_reg);
                case (cnt_reg[1:0])
                    2'd0: mem_wd = d100_reg;
                    2'd1: mem_wd = d10_reg;
                    default: mem_wd = acc_reg;
                endcase
            end
            S_MST:
            begin
                mem_we = 1'b1;
                mem_wa = i_reg[11:0] + 12'(cnt_reg);
                mem_wd = v_reg[cnt_reg[3:0]];
            end
            default: ;
        endcase
        if (state_reg == S_IDLE && start && operation == OP_LOAD)
        begin
            mem_we = 1'b1;
            mem_wa = load_address;
            mem_wd = load_data;
        end
        fw_set  = mem_we && (mem_wa < 12'd80);
        fw_addr = mem_wa;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fw_reg    <= '0;
            pc_reg    <= PROG_START;
            i_reg     <= 16'd0;
            sc_reg    <= '0;
            dt_reg    <= 8'd0;
            st_reg    <= 8'd0;
            done      <= 1'b0;
            for (int r = 0; r < 16; r++)
                v_reg[r] <= 8'd0;
            for (int r = 0; r < 32; r++)
                fb_reg[r] <= 64'd0;
        end
        else
        begin
            done <= 1'b0;
            if (fw_set)
                fw_reg[fw_addr[6:0]] <= 1'b1;
            raddr_reg   <= mem_ra;
            rd_font_reg <= (mem_ra < 12'd80);
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg   <= operation;
                        keys_reg <= keys_down;
                        rnd_reg  <= random_byte;
                        la_reg   <= load_address;
                        ld_reg   <= load_data;
                        rs_reg   <= row_select;
                        stat_reg <= ST_OK;
                        chg_reg  <= 1'b0;
                        if (operation == OP_EXEC)
                            state_reg <= S_F0;
                        else
                        begin
                            if (operation == OP_TICK)
                            begin
                                if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                                if (st_reg != 8'd0) st_reg <= st_reg - 8'd1;
                            end
                            state_reg <= S_ROW;
                        end
                    end
                end
                S_F0: state_reg <= S_F1;
                S_F1:
                begin
                    b0_reg    <= rd_byte;
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    b1_reg    <= rd_byte;
                    pc_reg    <= pc_inc;
                    cnt_reg   <= 5'd0;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_ROW;
                    case (b0_reg[7:4])
                        4'h0:
                        begin
                            if (b0_reg == 8'h00 && b1_reg == 8'hE0)
                            begin
                                chg_reg   <= 1'b1;
                                state_reg <= S_CLR;
                            end
                            else if (b0_reg == 8'h00 && b1_reg == 8'hEE)
                            begin
                                if (sc_reg == '0)
                                    stat_reg <= ST_UNDERFLOW;
                                else
                                begin
                                    sc_reg <= sc_reg - 1'b1;
                                    pc_reg <= stk[SPW'(sc_reg - 1'b1)];
                                end
                            end
                            else
                                stat_reg <= ST_BAD_OP;
                        end
                        4'h1: pc_reg <= {xr, b1_reg};
                        4'h2:
                        begin
                            if (sc_reg >= SCW'(STACK_DEPTH))
                                stat_reg <= ST_OVERFLOW;
                            else
                            begin
                                stk[SPW'(sc_reg)] <= pc_reg;
                                sc_reg <= sc_reg + 1'b1;
                                pc_reg <= {xr, b1_reg};
                            end
                        end
                        4'h3: if (vx == b1_reg) pc_reg <= pc_inc;
                        4'h4: if (vx != b1_reg) pc_reg <= pc_inc;
                        4'h5: if (vx == vy) pc_reg <= pc_inc;
                        4'h9: if (vx != vy) pc_reg <= pc_inc;
                        4'h6: v_reg[xr] <= b1_reg;
                        4'h7: v_reg[xr] <= alu_y.res;
                        4'h8:
                        begin
                            case (nl)
                                4'h0, 4'h1, 4'h2, 4'h3: v_reg[xr] <= alu_y.res;
                                4'h4, 4'h5, 4'h6, 4'h7, 4'hE:
                                begin
                                    // flag is written in the same cycle as the result and wins when x is 15
                                    v_reg[xr] <= alu_y.res;
                                    v_reg[15] <= {7'd0, alu_y.flag};
                                end
                                default: stat_reg <= ST_BAD_OP;
                            endcase
                        end
                        4'hA: i_reg <= {4'd0, xr, b1_reg};
                        4'hB: pc_reg <= {xr, b1_reg} + {4'd0, v_reg[0]};
                        4'hC: v_reg[xr] <= alu_y.res;
                        4'hD:
                        begin
                            chg_reg <= 1'b1;
                            hit_reg <= 1'b0;
                            if (nl == 4'd0)
                                v_reg[15] <= 8'd0;
                            else
                                state_reg <= S_DRD;
                        end
                        4'hE:
                        begin
                            if (b1_reg == 8'h9E)
                            begin
                                if (keys_reg[vx[3:0]]) pc_reg <= pc_inc;
                            end
                            else if (b1_reg == 8'hA1)
                            begin
                                if (!keys_reg[vx[3:0]]) pc_reg <= pc_inc;
                            end
                            else
                                stat_reg <= ST_BAD_OP;
                        end
                        default:
                        begin
                            case (b1_reg)
                                8'h07: v_reg[xr] <= dt_reg;
                                8'h0A:
                                begin
                                    if (key_any) v_reg[xr] <= {4'd0, key_lo};
                                    else pc_reg <= pc_reg - 12'd2;
                                end
                                8'h15: dt_reg <= vx;
                                8'h18: st_reg <= vx;
                                8'h1E: i_reg <= i_reg + {8'd0, vx};
                                8'h29: i_reg <= {8'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
                                8'h33:
                                begin
                                    acc_reg   <= vx;
                                    dig_reg   <= 2'd0;
                                    d100_reg  <= 8'd0;
                                    d10_reg   <= 8'd0;
                                    state_reg <= S_BCD;
                                end
                                8'h55: state_reg <= S_MST;
                                8'h65: state_reg <= S_MLD;
                                default: stat_reg <= ST_BAD_OP;
                            endcase
                        end
                    endcase
                end
                S_CLR:
                begin
                    fb_reg[cnt_reg] <= 64'd0;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        state_reg <= S_ROW;
                end
                S_DRD:
                begin
                    // address issued here; the data passes through mem_q, then mrd_reg
                    if (raddr_reg == i_reg[11:0] + 12'(cnt_reg) && state_reg == S_DRD
                        && mrd_reg == mrd_reg)
                        state_reg <= S_DRW;
                end
                S_DRW:
                begin
                    if ((fb_reg[srow] & smask) != 64'd0) hit_reg <= 1'b1;
                    fb_reg[srow] <= fb_reg[srow] ^ smask;
                    if (cnt_reg == 5'(nl) - 5'd1)
                    begin
                        v_reg[15] <= {7'd0, hit_reg | ((fb_reg[srow] & smask) != 64'd0)};
                        state_reg <= S_ROW;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 5'd1;
                        state_reg <= S_DRD;
                    end
                end
                S_BCD:
                begin
                    if (alu_y.flag)
                    begin
                        acc_reg <= alu_y.res;
                        if (dig_reg == 2'd0) d100_reg <= d100_reg + 8'd1;
                        else d10_reg <= d10_reg + 8'd1;
                    end
                    else if (dig_reg == 2'd0)
                        dig_reg <= 2'd1;
                    else
                    begin
                        cnt_reg   <= 5'd0;
                        state_reg <= S_BCDW;
                    end
                end
                S_BCDW:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd2)
                        state_reg <= S_ROW;
                end
                S_MST:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == xr)
                        state_reg <= S_ROW;
                end
                S_MLD:
                begin
                    if (raddr_reg == i_reg[11:0] + 12'(cnt_reg) && dig_reg == 2'd3)
                    begin
                        v_reg[cnt_reg[3:0]] <= rd_byte;
                        dig_reg <= 2'd0;
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg[3:0] == xr)
                            state_reg <= S_ROW;
                    end
                    else
                        dig_reg <= 2'd3;
                end
                S_ROW:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // sprite byte: the read data, registered in the cycle after it arrives
    always_ff @(posedge clk)
    begin
        mrd_reg <= rd_byte;
        if (state_reg == S_ROW)
            row_pixels <= fb_reg[rs_reg];
    end

    assign busy            = (state_reg != S_IDLE);
    assign status          = stat_reg;
    assign pc_now          = pc_reg;
    assign index_now       = i_reg;
    assign sound_on        = (st_reg != 8'd0);
    assign display_changed = chg_reg;

endmodule
